>>> rtl/sau_pkg.sv
// sau_pkg: shared types, sizes and codes for the stack arithmetic unit
// no dependencies; used by the channel interfaces, the shared alu and the top level
package sau_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ITER_W     = $clog2(WORD_WIDTH);
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ITER_W-1:0]     iter_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 3'd0,
    KIND_POP  = 3'd1,
    KIND_ADD  = 3'd2,
    KIND_SUB  = 3'd3,
    KIND_MUL  = 3'd4,
    KIND_DIV  = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  // sequencer to alu
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // alu to sequencer
  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

endpackage

>>> rtl/sau_if.sv
// sau_if: valid/ready channel interfaces for requests and results
// depends on sau_pkg for the word width and the kind, status and count widths
interface sau_in_if import sau_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [KIND_W-1:0]            kind;
  logic signed [WORD_WIDTH-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sau_out_if import sau_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] result_value;
  logic [STATUS_W-1:0]          status;
  logic [CNT_W-1:0]             item_count;

  modport source (output valid, output result_value, output status, output item_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input item_count,
                  output ready);
endinterface

>>> rtl/sau_alu.sv
// sau_alu: shared arithmetic unit, add/subtract in one step, shift-add multiply
// and restoring signed divide one bit per cycle; depends on sau_pkg
module sau_alu import sau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  input  word_t    a,      // top entry
  input  word_t    b,      // next entry
  output alu_rsp_t rsp
);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_FIX, A_DONE} alu_state_t;

  alu_state_t state_r;
  word_t      acc_r;   // product accumulator, final result
  word_t      x_r;     // multiplicand or divisor magnitude
  word_t      y_r;     // multiplier or dividend shifting into quotient
  word_t      rem_r;
  iter_t      cnt_r;
  logic       neg_r;

  logic [WORD_WIDTH:0] shifted;
  logic [WORD_WIDTH:0] diff;
  logic                last;

  assign shifted = {rem_r, y_r[WORD_WIDTH-1]};
  assign diff    = shifted - {1'b0, x_r};
  assign last    = (cnt_r == iter_t'(WORD_WIDTH - 1));

  assign rsp.done   = (state_r == A_DONE);
  assign rsp.result = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      case (state_r)
        A_IDLE: begin
          if (req.start) begin
            cnt_r <= '0;
            case (req.op)
              ALU_ADD: begin
                acc_r   <= a + b;
                state_r <= A_DONE;
              end
              ALU_SUB: begin
                acc_r   <= a - b;
                state_r <= A_DONE;
              end
              ALU_MUL: begin
                acc_r   <= '0;
                x_r     <= a;
                y_r     <= b;
                state_r <= A_MUL;
              end
              default: begin
                // next divided by top on magnitudes, sign fixed at the end
                x_r     <= a[WORD_WIDTH-1] ? (~a + word_t'(1)) : a;
                y_r     <= b[WORD_WIDTH-1] ? (~b + word_t'(1)) : b;
                rem_r   <= '0;
                neg_r   <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
                state_r <= A_DIV;
              end
            endcase
          end
        end
        A_MUL: begin
          if (y_r[0]) begin
            acc_r <= acc_r + x_r;
          end
          x_r   <= {x_r[WORD_WIDTH-2:0], 1'b0};
          y_r   <= {1'b0, y_r[WORD_WIDTH-1:1]};
          cnt_r <= cnt_r + iter_t'(1);
          if (last) begin
            state_r <= A_DONE;
          end
        end
        A_DIV: begin
          if (!diff[WORD_WIDTH]) begin
            rem_r <= diff[WORD_WIDTH-1:0];
            y_r   <= {y_r[WORD_WIDTH-2:0], 1'b1};
          end else begin
            rem_r <= shifted[WORD_WIDTH-1:0];
            y_r   <= {y_r[WORD_WIDTH-2:0], 1'b0};
          end
          cnt_r <= cnt_r + iter_t'(1);
          if (last) begin
            state_r <= A_FIX;
          end
        end
        A_FIX: begin
          acc_r   <= neg_r ? (~y_r + word_t'(1)) : y_r;
          state_r <= A_DONE;
        end
        A_DONE: begin
          state_r <= A_IDLE;
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/stack_arithmetic_unit.sv
// stack_arithmetic_unit: bounded stack of signed words with a shared alu
// depends on sau_pkg, sau_if (channel interfaces) and sau_alu
//
// usage: each request on in_ch carries a kind (push, pop, add, subtract,
// multiply, divide) and a value used only by push. each request gives exactly
// one result on out_ch: the popped word or the new top (zero when empty), a
// status (ok, underflow, stack full, divide by zero) and the entry count.
// in_ch.ready is high only while no request is in progress, so one request is
// worked at a time.
// steps from accept to out_ch.valid: a push with room goes straight to the
// output stage, as does any request on an empty stack; a full push, a pop
// and reads of the top wait for the registered stack read port; add,
// subtract, multiply and divide read the top and then the next entry, a
// divide by zero stops there, and the rest run in the alu, multiply and
// divide through its 32-step shift-add and shift-subtract loop.
// the result sits in an output register, so a new request is accepted while
// the previous result waits; if the receiver stalls, the next result is held
// inside until the output register frees up.
// reset (synchronous, rst_n low) empties the stack; stack words need no
// clearing since only entries below the count are read.
module stack_arithmetic_unit import sau_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sau_in_if.sink    in_ch,
  sau_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_TOP, S_NEXT, S_GO, S_WAIT, S_OUT} seq_state_t;

  seq_state_t state_r;
  kind_t      kind_r;
  word_t      t_r;
  word_t      res_r;
  status_t    stat_r;
  cnt_t       count_r;

  logic    out_valid_r;
  word_t   out_res_r;
  status_t out_stat_r;
  cnt_t    out_cnt_r;

  word_t mem [DEPTH];
  word_t rd_data_r;
  idx_t  rd_addr;
  logic  wr_en;
  idx_t  wr_addr;
  word_t wr_data;

  cnt_t cnt_m1;
  cnt_t cnt_m2;
  logic accept;
  logic divz;
  logic out_load;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign cnt_m1   = count_r - cnt_t'(1);
  assign cnt_m2   = count_r - cnt_t'(2);
  assign accept   = in_ch.valid && in_ch.ready;
  assign divz     = (kind_r == KIND_DIV) && (t_r == '0);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.status       = out_stat_r;
  assign out_ch.item_count   = out_cnt_r;

  // top is read on accept, next one in S_NEXT
  assign rd_addr = (state_r == S_NEXT) ? cnt_m2[IDX_W-1:0] : cnt_m1[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = word_t'(in_ch.value);
    if (state_r == S_IDLE) begin
      wr_en = accept && (kind_t'(in_ch.kind) == KIND_PUSH) && (count_r != cnt_t'(DEPTH));
    end else if (state_r == S_WAIT) begin
      wr_en   = alu_rsp.done;
      wr_addr = cnt_m2[IDX_W-1:0];
      wr_data = alu_rsp.result;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    alu_req.start = (state_r == S_GO) && !divz;
    case (kind_r)
      KIND_ADD: alu_req.op = ALU_ADD;
      KIND_SUB: alu_req.op = ALU_SUB;
      KIND_MUL: alu_req.op = ALU_MUL;
      default:  alu_req.op = ALU_DIV;
    endcase
  end

  sau_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (t_r),
    .b     (rd_data_r),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r <= kind_t'(in_ch.kind);
            stat_r <= ST_OK;
            res_r  <= '0;
            case (kind_t'(in_ch.kind))
              KIND_PUSH: begin
                if (count_r == cnt_t'(DEPTH)) begin
                  stat_r  <= ST_FULL;
                  state_r <= S_TOP;
                end else begin
                  res_r   <= word_t'(in_ch.value);
                  count_r <= count_r + cnt_t'(1);
                  state_r <= S_OUT;
                end
              end
              KIND_POP: begin
                if (count_r == '0) begin
                  stat_r  <= ST_UNDER;
                  state_r <= S_OUT;
                end else begin
                  count_r <= cnt_m1;
                  state_r <= S_TOP;
                end
              end
              KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                if (count_r < cnt_t'(2)) begin
                  stat_r  <= ST_UNDER;
                  state_r <= (count_r == '0) ? S_OUT : S_TOP;
                end else begin
                  state_r <= S_NEXT;
                end
              end
              default: begin
                // unused kinds just report the top
                state_r <= (count_r == '0) ? S_OUT : S_TOP;
              end
            endcase
          end
        end
        S_TOP: begin
          res_r   <= rd_data_r;
          state_r <= S_OUT;
        end
        S_NEXT: begin
          t_r     <= rd_data_r;
          state_r <= S_GO;
        end
        S_GO: begin
          if (divz) begin
            // dividend already sits in the next slot, just drop the top
            res_r   <= rd_data_r;
            stat_r  <= ST_DIVZ;
            count_r <= cnt_m1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            res_r   <= alu_rsp.result;
            count_r <= cnt_m1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_res_r   <= res_r;
            out_stat_r  <= stat_r;
            out_cnt_r   <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("entry count above depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("request accepted while another is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == ST_FULL) |-> (out_cnt_r == cnt_t'(DEPTH)))
    else $error("stack full reported with room left");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r == '0 && out_stat_r == ST_UNDER) |-> (out_res_r == '0))
    else $error("nonzero result from an empty stack");

  a_alu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_WAIT))
    else $error("alu result outside the wait state");

endmodule

>>> sim/sau_checker.sv
// sau_checker: watches the request and result channels of the stack arithmetic unit,
// keeps its own copy of the stack and compares every result with the predicted one
// depends on sau_pkg and sau_if
module sau_checker import sau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sau_in_if    in_ch,
  sau_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_count
);

  typedef struct packed {
    word_t               value;
    logic [STATUS_W-1:0] status;
    cnt_t                count;
  } stack_result_t;

  stack_result_t results_due[$];
  stack_result_t due;
  word_t         stack_words [DEPTH];
  cnt_t          depth_now;
  int            mismatches = 0;

  // signed divide through magnitudes, so most negative over minus one wraps
  function automatic word_t div_trunc(input word_t num, input word_t den);
    word_t num_mag;
    word_t den_mag;
    word_t quo;
    num_mag = num[WORD_WIDTH-1] ? -num : num;
    den_mag = den[WORD_WIDTH-1] ? -den : den;
    quo     = num_mag / den_mag;
    return (num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1]) ? -quo : quo;
  endfunction

  function automatic word_t top_word();
    return (depth_now == '0) ? '0 : stack_words[depth_now - 1];
  endfunction

  function automatic stack_result_t step_stack(input logic [KIND_W-1:0] kind,
                                               input word_t value);
    stack_result_t res;
    word_t         top;
    word_t         next;
    word_t         combined;
    res.status = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (depth_now == cnt_t'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          stack_words[depth_now] = value;
          depth_now++;
        end
        res.value = top_word();
      end
      KIND_POP: begin
        if (depth_now == '0) begin
          res.status = ST_UNDER;
          res.value  = '0;
        end else begin
          depth_now--;
          res.value = stack_words[depth_now];
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
        if (depth_now < 2) begin
          res.status = ST_UNDER;
        end else begin
          top  = stack_words[depth_now - 1];
          next = stack_words[depth_now - 2];
          case (kind)
            KIND_ADD: combined = top + next;
            KIND_SUB: combined = top - next;
            KIND_MUL: combined = top * next;
            KIND_DIV: begin
              // zero divisor: dividend goes back on the stack
              if (top == '0) begin
                combined   = next;
                res.status = ST_DIVZ;
              end else begin
                combined = div_trunc(next, top);
              end
            end
            default: combined = '0;
          endcase
          depth_now--;
          stack_words[depth_now - 1] = combined;
        end
        res.value = top_word();
      end
      // spare kind codes leave the stack alone
      default: res.value = top_word();
    endcase
    res.count = depth_now;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_now = '0;
      results_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        results_due.push_back(step_stack(in_ch.kind, in_ch.value));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("result with no request outstanding: value %h status %0d count %0d",
                     out_ch.result_value, out_ch.status, out_ch.item_count);
          end
          mismatches++;
        end else begin
          due = results_due.pop_front();
          if (out_ch.result_value !== due.value || out_ch.status !== due.status ||
              out_ch.item_count !== due.count) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected value %h status %0d count %0d",
                       due.value, due.status, due.count);
              $display("  got value %h status %0d count %0d",
                       out_ch.result_value, out_ch.status, out_ch.item_count);
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= results_due.size();
  end

endmodule

>>> sim/tb_stack_arithmetic_unit.sv
// tb_stack_arithmetic_unit: drives push, pop and arithmetic requests into the stack unit
// with random idling on both channels and gives the verdict; depends on sau_pkg, sau_if,
// stack_arithmetic_unit and sau_checker
module tb_stack_arithmetic_unit;
  import sau_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam word_t WORD_MIN = word_t'(1) << (WORD_WIDTH - 1);
  localparam word_t WORD_MAX = ~WORD_MIN;
  localparam int    REQS_PER_PHASE = 120;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   sent;
  int   send_idle_pct;
  int   recv_idle_pct;

  sau_in_if  in_ch ();
  sau_out_if out_ch ();

  stack_arithmetic_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sau_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (fail_count),
    .pending_count  (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return WORD_MIN;
      3:       return WORD_MAX;
      4:       return word_t'(1);
      5, 6:    return word_t'($urandom_range(8)) - word_t'(4);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_arith();
    case ($urandom_range(3))
      0:       return KIND_ADD;
      1:       return KIND_SUB;
      2:       return KIND_MUL;
      default: return KIND_DIV;
    endcase
  endfunction

  // valid stays high from one request to the next unless an idle cycle is drawn
  task automatic send_request(input logic [KIND_W-1:0] kind, input word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_requests(input int goal);
    int pick;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_request(KIND_PUSH, pick_word());
        send_request(KIND_PUSH, pick_word());
        send_request(pick_arith(), pick_word());
      end else if (pick < 45) begin
        send_request(KIND_PUSH, pick_word());
      end else if (pick < 65) begin
        send_request(KIND_POP, pick_word());
      end else if (pick < 88) begin
        send_request(pick_arith(), pick_word());
      end else if (pick < 94) begin
        // run into the full stack
        repeat (DEPTH + 1) send_request(KIND_PUSH, pick_word());
      end else begin
        // bring the stack down and keep going into underflow
        repeat (DEPTH + 1) begin
          if ($urandom_range(1) == 0) begin
            send_request(KIND_POP, pick_word());
          end else begin
            send_request(pick_arith(), pick_word());
          end
        end
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    sent          = 0;
    send_idle_pct = 31;
    recv_idle_pct = 52;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= KIND_PUSH;
    in_ch.value  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_POP, '0);
    send_request(KIND_ADD, '0);
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_SUB, '0);
    send_request(KIND_SPARE_LO, WORD_MAX);
    send_request(KIND_PUSH, word_t'(1));
    send_request(KIND_ADD, '0);
    send_request(KIND_PUSH, '1);
    send_request(KIND_DIV, '0);
    send_request(KIND_PUSH, '0);
    send_request(KIND_DIV, '0);
    send_request(KIND_PUSH, word_t'(-7));
    send_request(KIND_SUB, '0);
    send_request(KIND_PUSH, word_t'(-7));
    send_request(KIND_PUSH, word_t'(2));
    send_request(KIND_DIV, '0);
    send_request(KIND_MUL, '1);
    send_request(KIND_SPARE_HI, '0);
    repeat (DEPTH) send_request(KIND_PUSH, pick_word());
    send_request(KIND_POP, '0);

    random_requests(sent + REQS_PER_PHASE / 2);
    // hold off until the unit has caught up, then resume
    wait_drained();
    random_requests(sent + REQS_PER_PHASE / 2);
    wait_drained();

    send_idle_pct = 52;
    recv_idle_pct <= 31;
    random_requests(sent + REQS_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    random_requests(sent + REQS_PER_PHASE);
    wait_drained();

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_stack_arithmetic_unit passed");
    end else begin
      $display("tb_stack_arithmetic_unit failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_stack_arithmetic_unit failed");
    $finish;
  end

endmodule
